/* design/assert_macros.svh */
// Assertion macros for the stream find/replace RTL (included by sfr_back).
// Checks are compiled out when SYNTHESIS is defined; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SFR_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SFR_ASSERT(lbl, prop, msg)

`define SFR_NEVER(lbl, expr, msg)

`endif

`endif

/* design/sfr_pkg.sv */
// Shared types and constants for the stream find/replace block.
// No dependencies.
package sfr_pkg;

  localparam int unsigned MAX_NEEDLE_DEF = 8;
  localparam int unsigned MAX_SUB_DEF    = 8;
  localparam int unsigned LEN_W          = 4;   // needle_len / sub_len register width
  localparam int unsigned PACK_W         = 64;  // needle_bytes / sub_bytes width
  localparam int unsigned SNAP_W         = 64;  // window snapshot carried in a command
  localparam int unsigned BEAT_W         = 4;   // beat index within one command
  localparam int unsigned QDEPTH         = 2;
  localparam int unsigned ADDR_W         = 5;
  localparam int unsigned DATA_W         = 64;

  // register index (paddr[4:3])
  localparam logic [1:0] REG_NEEDLE_LEN   = 2'd0;
  localparam logic [1:0] REG_NEEDLE_BYTES = 2'd1;
  localparam logic [1:0] REG_SUB_LEN      = 2'd2;
  localparam logic [1:0] REG_SUB_BYTES    = 2'd3;

  // tuser bit positions on the result side
  localparam int unsigned TUSER_HAS    = 0;
  localparam int unsigned TUSER_STATUS = 1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]  needle_len;
    logic [PACK_W-1:0] needle_bytes;
    logic [LEN_W-1:0]  sub_len;
    logic [PACK_W-1:0] sub_bytes;
  } sfr_cfg_t;

  // one classified input item, handed from front to back
  typedef struct packed {
    logic              err;         // zero needle, last item
    logic              last;        // flush and mark end
    logic              emit1;       // mismatch: send oldest window byte
    logic              sub;         // match: send substitute
    logic [7:0]        one_byte;
    logic [BEAT_W-1:0] flush_cnt;
    logic [SNAP_W-1:0] flush_data;  // window bytes, byte 0 lowest
  } sfr_cmd_t;

endpackage

/* design/sfr_queue.sv */
// Two-entry command queue between front and back.
// Depends on sfr_pkg.
module sfr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfr_pkg::sfr_cmd_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output sfr_pkg::sfr_cmd_t rdata
);

  localparam int unsigned PW = $clog2(sfr_pkg::QDEPTH);

  sfr_pkg::sfr_cmd_t mem_r [sfr_pkg::QDEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [PW:0]       count_r;

  assign full  = (count_r == (PW+1)'(sfr_pkg::QDEPTH));
  assign valid = (count_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      priority case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* design/sfr_front.sv */
// Front end: takes input beats, keeps the match window, classifies each byte
// into a command for the back end. Depends on sfr_pkg.
module sfr_front #(
  parameter int unsigned MAX_NEEDLE = sfr_pkg::MAX_NEEDLE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sfr_pkg::sfr_cfg_t cfg,
  input  logic              cnt_clr,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] in_byte
  input  logic              in_tlast,
  output logic              q_push,
  output sfr_pkg::sfr_cmd_t q_cmd,
  input  logic              q_full
);

  localparam int unsigned CW = $clog2(MAX_NEEDLE + 1);

  logic [7:0]    win_r [MAX_NEEDLE];
  logic [CW-1:0] cnt_r;

  logic [7:0]    win_w [MAX_NEEDLE];
  logic [7:0]    win_s [MAX_NEEDLE];
  logic [CW-1:0] n_eff;
  logic [CW-1:0] c0;
  logic [CW-1:0] c1;
  logic [CW-1:0] c2;
  logic [CW-1:0] cnt_nxt;
  logic          n_zero;
  logic          full_win;
  logic          match;
  logic          accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    n_zero = (cfg.needle_len == '0);
    n_eff  = (cfg.needle_len > sfr_pkg::LEN_W'(MAX_NEEDLE)) ? CW'(MAX_NEEDLE)
                                                             : cfg.needle_len[CW-1:0];
    c0 = (cnt_r >= n_eff) ? '0 : cnt_r;
    c1 = c0 + 1'b1;
    full_win = (c1 == n_eff);

    match = 1'b1;
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      win_w[i] = (c0 == CW'(i)) ? in_tdata : win_r[i];
      if ((CW'(i) < n_eff) && (win_w[i] != cfg.needle_bytes[8*i +: 8])) match = 1'b0;
    end

    for (int i = 0; i < MAX_NEEDLE; i++) begin
      if (full_win && !match) begin
        win_s[i] = (i + 1 < MAX_NEEDLE) ? win_w[(i + 1) % MAX_NEEDLE] : 8'h00;
      end else begin
        win_s[i] = win_w[i];
      end
    end

    priority if (!full_win) c2 = c1;
    else if (match)         c2 = '0;
    else                    c2 = n_eff - 1'b1;

    q_cmd            = '0;
    q_cmd.err        = n_zero && in_tlast;
    q_cmd.last       = in_tlast;
    q_cmd.emit1      = !n_zero && full_win && !match;
    q_cmd.sub        = !n_zero && full_win && match;
    q_cmd.one_byte   = win_w[0];
    q_cmd.flush_cnt  = (!n_zero && in_tlast) ? sfr_pkg::BEAT_W'(c2) : '0;
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      q_cmd.flush_data[8*i +: 8] = win_s[i];
    end

    // a match with an empty substitute and no end mark leaves nothing to send
    q_push = accept && (in_tlast || q_cmd.emit1 ||
                        (q_cmd.sub && (cfg.sub_len != '0)));

    cnt_nxt = (n_zero || in_tlast) ? '0 : c2;
  end

  always_ff @(posedge clk) begin
    if (accept && !n_zero) begin
      for (int i = 0; i < MAX_NEEDLE; i++) win_r[i] <= win_s[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cnt_clr) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* design/sfr_back.sv */
// Back end: expands queued commands into result beats through an output register.
// Depends on sfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfr_back #(
  parameter int unsigned MAX_NEEDLE = sfr_pkg::MAX_NEEDLE_DEF,
  parameter int unsigned MAX_SUB    = sfr_pkg::MAX_SUB_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sfr_pkg::sfr_cfg_t cfg,
  input  logic              q_valid,
  input  sfr_pkg::sfr_cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] out_byte
  output logic [1:0]        out_tuser,  // [0] has_byte, [1] status
  output logic              out_tlast
);

  localparam int unsigned BW = sfr_pkg::BEAT_W;

  logic          out_tvalid_r;
  logic [7:0]    out_tdata_r;
  logic [1:0]    out_tuser_r;
  logic          out_tlast_r;
  logic [BW-1:0] idx_r;

  logic [BW-1:0] s_eff;
  logic [BW:0]   total;
  logic [BW-1:0] fi;
  logic [7:0]    sel_byte;
  logic          beat_go;
  logic          empty_cmd;
  logic          final_beat;
  logic          emit;

  always_comb begin
    s_eff = (cfg.sub_len > BW'(MAX_SUB)) ? BW'(MAX_SUB) : cfg.sub_len;
    total = {{BW{1'b0}}, q_cmd.emit1} + (q_cmd.sub ? {1'b0, s_eff} : '0)
          + {1'b0, q_cmd.flush_cnt};
    empty_cmd  = (total == '0);
    final_beat = (({1'b0, idx_r} + 1'b1) == total);

    priority if (q_cmd.emit1) fi = idx_r - 1'b1;
    else if (q_cmd.sub)       fi = idx_r - s_eff;
    else                      fi = idx_r;

    sel_byte = 8'h00;
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      if (fi == BW'(i)) sel_byte = q_cmd.flush_data[8*i +: 8];
    end
    if (q_cmd.emit1 && (idx_r == '0)) sel_byte = q_cmd.one_byte;
    if (q_cmd.sub && (idx_r < s_eff)) begin
      for (int i = 0; i < MAX_SUB; i++) begin
        if (idx_r == BW'(i)) sel_byte = cfg.sub_bytes[8*i +: 8];
      end
    end

    beat_go = q_valid && (!out_tvalid_r || out_tready);
    emit    = beat_go && !(empty_cmd && !q_cmd.last && !q_cmd.err);
    q_pop   = beat_go && (q_cmd.err || empty_cmd || final_beat);
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (q_cmd.err) begin
        out_tdata_r <= 8'h00;
        out_tuser_r[sfr_pkg::TUSER_HAS]    <= 1'b0;
        out_tuser_r[sfr_pkg::TUSER_STATUS] <= sfr_pkg::STATUS_INVALID;
        out_tlast_r <= 1'b1;
      end else if (empty_cmd) begin
        // bare end marker
        out_tdata_r <= 8'h00;
        out_tuser_r[sfr_pkg::TUSER_HAS]    <= 1'b0;
        out_tuser_r[sfr_pkg::TUSER_STATUS] <= sfr_pkg::STATUS_OK;
        out_tlast_r <= 1'b1;
      end else begin
        out_tdata_r <= sel_byte;
        out_tuser_r[sfr_pkg::TUSER_HAS]    <= 1'b1;
        out_tuser_r[sfr_pkg::TUSER_STATUS] <= sfr_pkg::STATUS_OK;
        out_tlast_r <= q_cmd.last && final_beat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (q_pop) begin
        idx_r <= '0;
      end else if (beat_go) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `SFR_NEVER(a_pop_empty, q_pop && !q_valid, "command popped from empty queue")
  `SFR_ASSERT(a_err_marker, out_tvalid_r && out_tuser_r[sfr_pkg::TUSER_STATUS] |-> out_tlast_r && !out_tuser_r[sfr_pkg::TUSER_HAS], "invalid status beat is not a bare end marker")
  `SFR_ASSERT(a_idx_rewind, $past(q_pop) |-> idx_r == '0, "beat index not rewound after command")
  `SFR_NEVER(a_idx_range, {1'b0, idx_r} >= (BW+1)'(MAX_NEEDLE + MAX_SUB), "beat index out of range")

endmodule

/* design/stream_find_replace_top.sv */
// Stream find/replace: one input beat per cycle while the queue is not full; a result
// beat passes through the queue and the output register. A byte that yields at most one result
// sustains 1 beat/cycle while out_tready is high; a match yields sub_len beats and a last beat
// up to MAX_NEEDLE. A two-entry command queue lets input continue while a burst drains.
// rst_n is synchronous: registers return to needle_len 1, others 0, window empty.
// Depends on sfr_pkg, sfr_front, sfr_queue, sfr_back.
module stream_find_replace_top #(
  parameter int unsigned MAX_NEEDLE = sfr_pkg::MAX_NEEDLE_DEF,
  parameter int unsigned MAX_SUB    = sfr_pkg::MAX_SUB_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] in_byte
  input  logic                       in_tlast,   // in_last
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] out_byte
  output logic [1:0]                 out_tuser,  // [0] has_byte, [1] status
  output logic                       out_tlast,  // out_last
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [sfr_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [sfr_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  sfr_pkg::sfr_cfg_t cfg_r;
  logic              cfg_wr;
  logic              cnt_clr;
  logic [1:0]        reg_idx;

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  sfr_pkg::sfr_cmd_t q_wcmd;
  sfr_pkg::sfr_cmd_t q_rcmd;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cnt_clr    = cfg_wr && (reg_idx == sfr_pkg::REG_NEEDLE_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.needle_len   <= sfr_pkg::LEN_W'(1);
      cfg_r.needle_bytes <= '0;
      cfg_r.sub_len      <= '0;
      cfg_r.sub_bytes    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sfr_pkg::REG_NEEDLE_LEN:   cfg_r.needle_len   <= cfg_pwdata[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_NEEDLE_BYTES: cfg_r.needle_bytes <= cfg_pwdata;
        sfr_pkg::REG_SUB_LEN:      cfg_r.sub_len      <= cfg_pwdata[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_SUB_BYTES:    cfg_r.sub_bytes    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sfr_pkg::REG_NEEDLE_LEN:   cfg_prdata = sfr_pkg::DATA_W'(cfg_r.needle_len);
      sfr_pkg::REG_NEEDLE_BYTES: cfg_prdata = cfg_r.needle_bytes;
      sfr_pkg::REG_SUB_LEN:      cfg_prdata = sfr_pkg::DATA_W'(cfg_r.sub_len);
      sfr_pkg::REG_SUB_BYTES:    cfg_prdata = cfg_r.sub_bytes;
      default:                   cfg_prdata = '0;
    endcase
  end

  sfr_front #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cnt_clr   (cnt_clr),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_push    (q_push),
    .q_cmd     (q_wcmd),
    .q_full    (q_full)
  );

  sfr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wcmd),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rcmd)
  );

  sfr_back #(
    .MAX_NEEDLE (MAX_NEEDLE),
    .MAX_SUB    (MAX_SUB)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_cmd      (q_rcmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* tb/stream_find_replace_top_test.sv */
// Self-checking bench for stream_find_replace_top: drives text beats and APB register writes,
// predicts the rewritten stream and compares every result beat field by field.
// Depends on sfr_pkg and the stream_find_replace_top RTL.
module stream_find_replace_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
    logic       status;
  } rewrite_beat_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_CHECKED} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [1:0]    reg_idx;
    logic [63:0]   value;
    logic [7:0]    data;
    logic          last;
    rewrite_beat_t want;
  } stim_row_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int TAIL_CYCLES    = 20;
  localparam int HOLD_CYCLES    = 60;
  localparam int PHASE_ITEMS    = 12;
  localparam int NUM_PHASES     = 6;
  localparam int N_DIRECTED     = 35;
  localparam rewrite_beat_t NO_BEAT = '0;

  logic                         clk         = 1'b0;
  logic                         rst_n       = 1'b0;
  logic                         in_tvalid   = 1'b0;
  logic                         in_tready;
  logic [7:0]                   in_tdata    = 8'h00;  // [7:0] in_byte
  logic                         in_tlast    = 1'b0;   // in_last
  logic                         out_tvalid;
  logic                         out_tready  = 1'b0;
  logic [7:0]                   out_tdata;            // [7:0] out_byte
  logic [1:0]                   out_tuser;            // [0] has_byte, [1] status
  logic                         out_tlast;            // out_last
  logic                         cfg_psel    = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite  = 1'b0;
  logic [sfr_pkg::ADDR_W-1:0]   cfg_paddr   = '0;
  logic [sfr_pkg::DATA_W-1:0]   cfg_pwdata  = '0;
  logic [sfr_pkg::DATA_W-1:0]   cfg_prdata;
  logic                         cfg_pready;

  // predictor copy of the registers and the match window
  logic [3:0]    cur_nl = 4'd1;
  logic [63:0]   cur_nb = '0;
  logic [3:0]    cur_sl = 4'd0;
  logic [63:0]   cur_sb = '0;
  logic [7:0]    win [8];
  int            win_cnt = 0;

  rewrite_beat_t step_beats [$];
  rewrite_beat_t rewrite_q [$];

  int errors      = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  int hold_left   = 0;
  int hold_seen   = 0;
  int hold_ticket = 0;
  bit calm        = 1'b0;

  stim_row_t directed_tab [N_DIRECTED] = '{
    // reset values: needle is a single zero byte, no substitute
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h00, 1'b0, NO_BEAT},
    '{ROW_CHECKED, sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h41, 1'b1,
      '{8'h41, 1'b1, 1'b1, sfr_pkg::STATUS_OK}},
    '{ROW_CHECKED, sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h00, 1'b1,
      '{8'h00, 1'b0, 1'b1, sfr_pkg::STATUS_OK}},
    // zero needle: bytes dropped, error on the last beat
    '{ROW_CFG,     sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h00, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'hFF, 1'b0, NO_BEAT},
    '{ROW_CHECKED, sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h12, 1'b1,
      '{8'h00, 1'b0, 1'b1, sfr_pkg::STATUS_INVALID}},
    '{ROW_CFG,     sfr_pkg::REG_NEEDLE_LEN,   64'd3, 8'h00, 1'b0, NO_BEAT},
    '{ROW_CFG,     sfr_pkg::REG_NEEDLE_BYTES, 64'h636261, 8'h00, 1'b0, NO_BEAT},
    '{ROW_CFG,     sfr_pkg::REG_SUB_LEN,      64'd8, 8'h00, 1'b0, NO_BEAT},
    '{ROW_CFG,     sfr_pkg::REG_SUB_BYTES,    64'h8877665544332211, 8'h00, 1'b0, NO_BEAT},
    // rewriting needle_len drops the two pending bytes
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h61, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h62, 1'b0, NO_BEAT},
    '{ROW_CFG,     sfr_pkg::REG_NEEDLE_LEN, 64'd3, 8'h00, 1'b0, NO_BEAT},
    '{ROW_CHECKED, sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h63, 1'b1,
      '{8'h63, 1'b1, 1'b1, sfr_pkg::STATUS_OK}},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h78, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h61, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h62, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h63, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h61, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h62, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h63, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h61, 1'b1, NO_BEAT},
    // oversized lengths clamp to eight
    '{ROW_CFG,     sfr_pkg::REG_NEEDLE_LEN,   64'd15, 8'h00, 1'b0, NO_BEAT},
    '{ROW_CFG,     sfr_pkg::REG_NEEDLE_BYTES, 64'hFFFFFFFFFFFFFFFF, 8'h00, 1'b0, NO_BEAT},
    '{ROW_CFG,     sfr_pkg::REG_SUB_LEN,      64'd15, 8'h00, 1'b0, NO_BEAT},
    '{ROW_CFG,     sfr_pkg::REG_SUB_BYTES,    64'h00FF00FF00FF00FF, 8'h00, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'hFF, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'hFF, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'hFF, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'hFF, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'hFF, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'hFF, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'hFF, 1'b0, NO_BEAT},
    '{ROW_ITEM,    sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'hFF, 1'b0, NO_BEAT},
    '{ROW_CHECKED, sfr_pkg::REG_NEEDLE_LEN, 64'h0, 8'h80, 1'b1,
      '{8'h80, 1'b1, 1'b1, sfr_pkg::STATUS_OK}}
  };

  stream_find_replace_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  function automatic int needle_eff();
    return (cur_nl > 4'd8) ? 8 : int'(cur_nl);
  endfunction

  // Rewrites one text byte; the beats it releases land in step_beats.
  function automatic void rewrite_step(input logic [7:0] b, input logic l);
    int  n;
    int  s;
    int  c;
    bit  hit;
    rewrite_beat_t beat;
    step_beats.delete();
    n = needle_eff();
    s = (cur_sl > 4'd8) ? 8 : int'(cur_sl);
    c = win_cnt;
    if (n == 0) begin
      win_cnt = 0;
      if (l)
        step_beats.push_back('{8'h00, 1'b0, 1'b1, sfr_pkg::STATUS_INVALID});
      return;
    end
    if (c >= n)
      c = 0;
    win[c] = b;
    c++;
    if (c == n) begin
      hit = 1'b1;
      for (int i = 0; i < n; i++)
        if (win[i] != cur_nb[8*i +: 8])
          hit = 1'b0;
      if (hit) begin
        for (int i = 0; i < s; i++)
          step_beats.push_back('{cur_sb[8*i +: 8], 1'b1, 1'b0, sfr_pkg::STATUS_OK});
        c = 0;
      end else begin
        step_beats.push_back('{win[0], 1'b1, 1'b0, sfr_pkg::STATUS_OK});
        for (int i = 1; i < n; i++)
          win[i-1] = win[i];
        c = n - 1;
      end
    end
    if (l) begin
      for (int i = 0; i < c; i++)
        step_beats.push_back('{win[i], 1'b1, 1'b0, sfr_pkg::STATUS_OK});
      c = 0;
      if (step_beats.size() == 0) begin
        step_beats.push_back('{8'h00, 1'b0, 1'b1, sfr_pkg::STATUS_OK});
      end else begin
        beat = step_beats.pop_back();
        beat.out_last = 1'b1;
        step_beats.push_back(beat);
      end
    end
    win_cnt = c;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      sfr_pkg::REG_NEEDLE_LEN: begin
        cur_nl  = v[3:0];
        win_cnt = 0;
      end
      sfr_pkg::REG_NEEDLE_BYTES: cur_nb = v;
      sfr_pkg::REG_SUB_LEN:      cur_sl = v[3:0];
      sfr_pkg::REG_SUB_BYTES:    cur_sb = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Quiet the input and let the block empty out, including beats that give no result.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (rewrite_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input logic [7:0] b, input logic l, input logic typed,
                           input rewrite_beat_t want);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (in_tready !== 1'b1);
    rewrite_step(b, l);
    if (typed)
      rewrite_q.push_back(want);
    else
      foreach (step_beats[i]) rewrite_q.push_back(step_beats[i]);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // One text: needles, broken needle prefixes, needle bytes and noise, closed by tlast.
  task automatic send_text(inout int sent);
    logic [7:0] text_q [$];
    int n;
    int k;
    n = needle_eff();
    repeat ($urandom_range(1, 4)) begin
      if (n == 0) begin
        text_q.push_back(8'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3:
            for (int i = 0; i < n; i++) text_q.push_back(cur_nb[8*i +: 8]);
          4, 5: begin
            k = (n > 1) ? $urandom_range(1, n - 1) : 1;
            for (int i = 0; i < k; i++) text_q.push_back(cur_nb[8*i +: 8]);
          end
          6, 7: begin
            k = $urandom_range(0, n - 1);
            text_q.push_back(cur_nb[8*k +: 8]);
          end
          default: text_q.push_back(8'($urandom));
        endcase
      end
    end
    foreach (text_q[j])
      send_item(text_q[j], j == text_q.size() - 1, 1'b0, NO_BEAT);
    sent += text_q.size();
  endtask

  // result side: checker, random back-pressure and the long hold-off
  always @(posedge clk) begin : result_side
    rewrite_beat_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (rewrite_q.size() == 0) begin
          $error("unexpected result beat: out_byte %h, has_byte %b, out_last %b, status %b",
                 out_tdata, out_tuser[sfr_pkg::TUSER_HAS], out_tlast,
                 out_tuser[sfr_pkg::TUSER_STATUS]);
          errors++;
        end else begin
          want = rewrite_q.pop_front();
          if (out_tdata !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_tdata);
            errors++;
          end
          if (out_tuser[sfr_pkg::TUSER_HAS] !== want.has_byte) begin
            $error("has_byte: expected %b, got %b", want.has_byte,
                   out_tuser[sfr_pkg::TUSER_HAS]);
            errors++;
          end
          if (out_tlast !== want.out_last) begin
            $error("out_last: expected %b, got %b", want.out_last, out_tlast);
            errors++;
          end
          if (out_tuser[sfr_pkg::TUSER_STATUS] !== want.status) begin
            $error("status: expected %b, got %b", want.status,
                   out_tuser[sfr_pkg::TUSER_STATUS]);
            errors++;
          end
        end
      end
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int  sent;
    bit  paused;
    logic [3:0] nl;
    logic [3:0] sl;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_tab[r]) begin
      case (directed_tab[r].kind)
        ROW_CFG: begin
          drain();
          cfg_write(directed_tab[r].reg_idx, directed_tab[r].value);
        end
        ROW_ITEM:
          send_item(directed_tab[r].data, directed_tab[r].last, 1'b0, NO_BEAT);
        default:
          send_item(directed_tab[r].data, directed_tab[r].last, 1'b1, directed_tab[r].want);
      endcase
    end

    // random phases; first three pin the extremes of the lengths
    paused = 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0: begin nl = 4'd1; sl = 4'd8; end
        1: begin nl = 4'd8; sl = 4'd0; end
        2: begin nl = 4'd0; sl = 4'($urandom_range(0, 15)); end
        default: begin
          nl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
          sl = 4'($urandom_range(0, 15));
        end
      endcase
      cfg_write(sfr_pkg::REG_NEEDLE_LEN, {60'($urandom), nl});
      cfg_write(sfr_pkg::REG_NEEDLE_BYTES, {$urandom, $urandom});
      cfg_write(sfr_pkg::REG_SUB_LEN, {60'($urandom), sl});
      cfg_write(sfr_pkg::REG_SUB_BYTES, {$urandom, $urandom});
      if (p == NUM_PHASES - 1)
        calm = 1'b1;
      if (p == 0)
        hold_ticket++;  // receiver sits out while eight-beat substitutes pile up
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (p == 1 && !paused && sent >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          if (rewrite_q.size() != 0) begin
            in_tvalid <= 1'b0;
            while (rewrite_q.size() != 0) @(posedge clk);
          end
        end
        send_text(sent);
      end
    end

    in_tvalid <= 1'b0;
    while (rewrite_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
